// File: rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and codes of the first-fit aligned free list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic REG_POOL0_CAP = 1'b0;
  localparam logic REG_POOL1_CAP = 1'b1;

  // slave beat: req_size, align_log2, block_offset
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned S_TUSER_W = 2;
  // master beat: status, alloc_offset, used_bytes, free_block_count
  localparam int unsigned M_TDATA_W = 80;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_FPLAN,
    SEQ_SHIFT,
    SEQ_WRA,
    SEQ_WRB,
    SEQ_DONE
  } seq_state_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_UP,
    SH_DOWN
  } shift_dir_e;

  typedef struct packed {
    logic inc;
    logic dec;
    logic add;
    logic sub;
    logic clr_fresh;
  } pool_cmd_t;

endpackage

// File: rtl/first_fit_aligned_free_list_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_aligned_free_list_allocator
// Two-pool first-fit allocator with alignment and free-block coalescing.
// ----------------------------------------------------------------------------
// Requests enter as beats on the slave stream: tuser selects allocate or free
// and the pool, tdata carries size, alignment exponent and freed offset.
// Each request returns one beat on the master stream with status, granted
// offset, bytes in use and the pool's free block count.
// The free tables of both pools sit in one RAM with a registered read port.
// A request scans its pool's table one entry per cycle until the first fit
// (allocate) or the insert point (free), then shifts the tail of the table
// one entry per cycle when an entry is inserted or removed, and writes back
// up to two entries. The input is ready again as soon as the result is
// loaded into the output register.
// One request is in flight at a time; the next is taken once the result is
// in the output register, even while that beat still waits for tready.
// A stalled master side holds the result and blocks the following request
// from completing. Reset and a write of a capacity register leave the pool
// as one free block at offset 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_aligned_free_list_allocator #(
  parameter int unsigned MAX_FREE_BLOCKS = 64,
  parameter int unsigned ADDR_BITS       = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // req_size[31:0], align_log2[36:32], block_offset[68:37]
  input  logic [ffa_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // kind[0], pool_select[1]
  input  logic [ffa_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status[1:0], alloc_offset[33:2], used_bytes[65:34], free_block_count[72:66]
  output logic [ffa_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned CNT_W = $clog2(MAX_FREE_BLOCKS + 1);
  localparam int unsigned IW    = $clog2(MAX_FREE_BLOCKS);
  localparam int unsigned DW    = 2 * ADDR_BITS + 1;

  logic [1:0]                fresh;
  logic [1:0][ADDR_BITS-1:0] cap;
  logic [1:0][CNT_W-1:0]     cnt;
  logic [1:0][31:0]          bytes;
  logic                      pool;
  ffa_pkg::pool_cmd_t        cmd;
  logic [31:0]               amount;
  logic                      ram_we, ram_re;
  logic [IW:0]               ram_waddr, ram_raddr;
  logic [DW-1:0]             ram_wdata, ram_rdata;

  ffa_pool_regs #(
    .MAX_FREE_BLOCKS(MAX_FREE_BLOCKS),
    .ADDR_BITS      (ADDR_BITS)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pool_i     (pool),
    .cmd_i      (cmd),
    .amount_i   (amount),
    .fresh_o    (fresh),
    .cap_o      (cap),
    .cnt_o      (cnt),
    .bytes_o    (bytes)
  );

  ffa_ram #(
    .WIDTH(DW),
    .DEPTH(2 ** (IW + 1))
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ffa_seq #(
    .MAX_FREE_BLOCKS(MAX_FREE_BLOCKS),
    .ADDR_BITS      (ADDR_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .fresh_i        (fresh),
    .cap_i          (cap),
    .cnt_i          (cnt),
    .bytes_i        (bytes),
    .pool_o         (pool),
    .cmd_o          (cmd),
    .amount_o       (amount),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

endmodule

// File: rtl/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/ffa_pool_regs.sv
// ----------------------------------------------------------------------------
// ffa_pool_regs
// Per-pool capacity, fresh flag, free block count and bytes in use.
// ----------------------------------------------------------------------------
module ffa_pool_regs #(
  parameter int unsigned MAX_FREE_BLOCKS = 64,
  parameter int unsigned ADDR_BITS       = 32,
  localparam int unsigned CNT_W = $clog2(MAX_FREE_BLOCKS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [31:0]                     cfg_wdata_i,
  input  logic                            pool_i,
  input  ffa_pkg::pool_cmd_t              cmd_i,
  input  logic [31:0]                     amount_i,
  output logic [1:0]                      fresh_o,
  output logic [1:0][ADDR_BITS-1:0]       cap_o,
  output logic [1:0][CNT_W-1:0]           cnt_o,
  output logic [1:0][31:0]                bytes_o
);

  localparam int unsigned XW = (ADDR_BITS > 32) ? ADDR_BITS : 32;
  localparam logic [ADDR_BITS-1:0] AMAX = '1;

  logic [1:0]                fresh_q, fresh_d;
  logic [1:0][ADDR_BITS-1:0] cap_q, cap_d;
  logic [1:0][CNT_W-1:0]     cnt_q, cnt_d;
  logic [1:0][31:0]          bytes_q, bytes_d;
  logic [XW-1:0]             cfg_ext;
  logic [ADDR_BITS-1:0]      cfg_clamped;
  logic [32:0]               add_sum;

  assign cfg_ext     = XW'(cfg_wdata_i);
  assign cfg_clamped = (cfg_ext > XW'(AMAX)) ? AMAX : cfg_ext[ADDR_BITS-1:0];
  assign add_sum     = {1'b0, bytes_q[pool_i]} + {1'b0, amount_i};

  always_comb begin
    fresh_d = fresh_q;
    cap_d   = cap_q;
    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    if (cfg_we_i) begin
      cap_d[cfg_idx_i]   = cfg_clamped;
      fresh_d[cfg_idx_i] = 1'b1;
      cnt_d[cfg_idx_i]   = CNT_W'(1);
      bytes_d[cfg_idx_i] = '0;
    end else begin
      if (cmd_i.clr_fresh) begin
        fresh_d[pool_i] = 1'b0;
      end
      if (cmd_i.inc) begin
        cnt_d[pool_i] = cnt_q[pool_i] + CNT_W'(1);
      end else if (cmd_i.dec) begin
        cnt_d[pool_i] = cnt_q[pool_i] - CNT_W'(1);
      end
      if (cmd_i.add) begin
        bytes_d[pool_i] = add_sum[32] ? '1 : add_sum[31:0];
      end else if (cmd_i.sub) begin
        bytes_d[pool_i] = (bytes_q[pool_i] >= amount_i) ? bytes_q[pool_i] - amount_i : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= '1;
      cap_q   <= '0;
      cnt_q   <= {2{CNT_W'(1)}};
      bytes_q <= '0;
    end else begin
      fresh_q <= fresh_d;
      cap_q   <= cap_d;
      cnt_q   <= cnt_d;
      bytes_q <= bytes_d;
    end
  end

  assign fresh_o = fresh_q;
  assign cap_o   = cap_q;
  assign cnt_o   = cnt_q;
  assign bytes_o = bytes_q;

endmodule

// File: rtl/ffa_seq.sv
// ----------------------------------------------------------------------------
// ffa_seq
// Request sequencer: table scan, planning, shift and write-back, result beat.
// ----------------------------------------------------------------------------
module ffa_seq #(
  parameter int unsigned MAX_FREE_BLOCKS = 64,
  parameter int unsigned ADDR_BITS       = 32,
  localparam int unsigned CNT_W = $clog2(MAX_FREE_BLOCKS + 1),
  localparam int unsigned IW    = $clog2(MAX_FREE_BLOCKS),
  localparam int unsigned OW    = ADDR_BITS + 1,
  localparam int unsigned DW    = ADDR_BITS + OW
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [ffa_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic [ffa_pkg::S_TUSER_W-1:0]    s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [ffa_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  input  logic [1:0]                       fresh_i,
  input  logic [1:0][ADDR_BITS-1:0]        cap_i,
  input  logic [1:0][CNT_W-1:0]            cnt_i,
  input  logic [1:0][31:0]                 bytes_i,
  output logic                             pool_o,
  output ffa_pkg::pool_cmd_t               cmd_o,
  output logic [31:0]                      amount_o,
  output logic                             ram_we_o,
  output logic [IW:0]                      ram_waddr_o,
  output logic [DW-1:0]                    ram_wdata_o,
  output logic                             ram_re_o,
  output logic [IW:0]                      ram_raddr_o,
  input  logic [DW-1:0]                    ram_rdata_i
);

  localparam int unsigned CW   = ((OW > 32) ? OW : 32) + 2;
  localparam int unsigned XW   = (ADDR_BITS > 32) ? ADDR_BITS : 32;
  localparam int unsigned CXW  = CNT_W + 7;
  localparam int unsigned MPAD = ffa_pkg::M_TDATA_W - 73;
  localparam logic [ADDR_BITS-1:0] AMAX = '1;

  ffa_pkg::seq_state_e state_q, state_d;
  ffa_pkg::shift_dir_e dir_q, dir_d;

  logic                 kind_q, kind_d, pool_q, pool_d;
  logic [31:0]          size_q, size_d, boff_q, boff_d;
  logic [4:0]           alg_q, alg_d;
  logic [CNT_W-1:0]     n_q, n_d, ridx_q, ridx_d, j_q, j_d, lo_q, lo_d;
  logic [CNT_W-1:0]     sh_q, sh_d, shw_q, shw_d;
  logic                 rv_q, rfresh_q;
  logic [OW-1:0]        prev_off_q, prev_off_d, cur_off_q, cur_off_d;
  logic [ADDR_BITS-1:0] prev_sz_q, prev_sz_d, cur_sz_q, cur_sz_d;
  logic                 prev_vld_q, prev_vld_d, cur_vld_q, cur_vld_d;
  logic                 wa_en_q, wa_en_d, wb_en_q, wb_en_d;
  logic [CNT_W-1:0]     wa_idx_q, wa_idx_d, wb_idx_q, wb_idx_d;
  logic [OW-1:0]        wa_off_q, wa_off_d, wb_off_q, wb_off_d;
  logic [ADDR_BITS-1:0] wa_sz_q, wa_sz_d, wb_sz_q, wb_sz_d;
  logic [1:0]           status_q, status_d;
  logic [31:0]          aoff_q, aoff_d;
  logic                 mv_q, mv_d;
  logic [ffa_pkg::M_TDATA_W-1:0] md_q, md_d;

  logic                 accept, re, we, rfresh_d;
  logic [CNT_W-1:0]     ra, wi, iidx;
  logic [DW-1:0]        wd;
  logic [OW-1:0]        e_off;
  logic [ADDR_BITS-1:0] e_sz;
  logic [CW-1:0]        a_m1, al, pad, need, rem;
  logic                 fit, ge, hit, scan_end;
  logic [XW-1:0]        boff_ext, size_ext;
  logic [ADDR_BITS-1:0] boffc, sizec;
  logic [CW-1:0]        sum_both, sum_next, sum_prev;
  logic [ADDR_BITS-1:0] sat_both, sat_next, sat_prev;
  logic                 mn, mp, sh_issue, sh_done;
  logic [CXW-1:0]       cnt_ext;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ffa_pkg::SEQ_IDLE);

  // entry read back, entry 0 of a freshly set pool reads as the whole pool
  assign e_off = rfresh_q ? '0 : ram_rdata_i[OW-1:0];
  assign e_sz  = rfresh_q ? cap_i[pool_q] : ram_rdata_i[DW-1:OW];

  assign boff_ext = XW'(boff_q);
  assign size_ext = XW'(size_q);
  assign boffc = (boff_ext > XW'(AMAX)) ? AMAX : boff_ext[ADDR_BITS-1:0];
  assign sizec = (size_ext > XW'(AMAX)) ? AMAX : size_ext[ADDR_BITS-1:0];

  assign a_m1 = (CW'(1) << alg_q) - CW'(1);
  assign al   = (CW'(e_off) + a_m1) & ~a_m1;
  assign pad  = al - CW'(e_off);
  assign need = pad + CW'(size_q);
  assign fit  = need <= CW'(e_sz);
  assign rem  = CW'(e_sz) - need;
  assign ge   = CW'(e_off) >= CW'(boffc);

  assign hit      = rv_q && ((kind_q == ffa_pkg::KIND_ALLOC) ? fit : ge);
  assign scan_end = hit || (ridx_q == n_q);
  assign iidx     = ridx_q - CNT_W'(1);

  assign mn = cur_vld_q && (CW'(boffc) + CW'(sizec) == CW'(cur_off_q));
  assign mp = prev_vld_q && (CW'(prev_off_q) + CW'(prev_sz_q) == CW'(boffc));
  assign sum_both = CW'(prev_sz_q) + CW'(sizec) + CW'(cur_sz_q);
  assign sum_next = CW'(cur_sz_q) + CW'(sizec);
  assign sum_prev = CW'(prev_sz_q) + CW'(sizec);
  assign sat_both = (sum_both > CW'(AMAX)) ? AMAX : sum_both[ADDR_BITS-1:0];
  assign sat_next = (sum_next > CW'(AMAX)) ? AMAX : sum_next[ADDR_BITS-1:0];
  assign sat_prev = (sum_prev > CW'(AMAX)) ? AMAX : sum_prev[ADDR_BITS-1:0];

  assign sh_issue = (dir_q == ffa_pkg::SH_UP)   ? (sh_q > lo_q) :
                    (dir_q == ffa_pkg::SH_DOWN) ? (sh_q < n_q)  : 1'b0;
  assign sh_done  = !sh_issue && !rv_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ffa_pkg::SEQ_IDLE: begin
        if (accept) begin
          state_d = ffa_pkg::SEQ_SCAN;
        end
      end
      ffa_pkg::SEQ_SCAN: begin
        if (scan_end) begin
          if (kind_q == ffa_pkg::KIND_FREE) begin
            state_d = ffa_pkg::SEQ_FPLAN;
          end else if (!hit || (pad != '0 && rem != '0
                                && n_q >= CNT_W'(MAX_FREE_BLOCKS))) begin
            state_d = ffa_pkg::SEQ_DONE;
          end else begin
            state_d = ffa_pkg::SEQ_SHIFT;
          end
        end
      end
      ffa_pkg::SEQ_FPLAN: begin
        if (!mn && !mp && n_q >= CNT_W'(MAX_FREE_BLOCKS)) begin
          state_d = ffa_pkg::SEQ_DONE;
        end else begin
          state_d = ffa_pkg::SEQ_SHIFT;
        end
      end
      ffa_pkg::SEQ_SHIFT: begin
        if (sh_done) begin
          state_d = ffa_pkg::SEQ_WRA;
        end
      end
      ffa_pkg::SEQ_WRA:  state_d = ffa_pkg::SEQ_WRB;
      ffa_pkg::SEQ_WRB:  state_d = ffa_pkg::SEQ_DONE;
      ffa_pkg::SEQ_DONE: begin
        if (!mv_q || m_axis_tready_i) begin
          state_d = ffa_pkg::SEQ_IDLE;
        end
      end
      default: state_d = ffa_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    kind_d = kind_q; pool_d = pool_q; size_d = size_q; boff_d = boff_q; alg_d = alg_q;
    n_d = n_q; ridx_d = ridx_q; j_d = j_q; lo_d = lo_q; sh_d = sh_q; shw_d = shw_q;
    dir_d = dir_q;
    prev_off_d = prev_off_q; prev_sz_d = prev_sz_q; prev_vld_d = prev_vld_q;
    cur_off_d = cur_off_q; cur_sz_d = cur_sz_q; cur_vld_d = cur_vld_q;
    wa_en_d = wa_en_q; wa_idx_d = wa_idx_q; wa_off_d = wa_off_q; wa_sz_d = wa_sz_q;
    wb_en_d = wb_en_q; wb_idx_d = wb_idx_q; wb_off_d = wb_off_q; wb_sz_d = wb_sz_q;
    status_d = status_q; aoff_d = aoff_q;
    mv_d = mv_q; md_d = md_q;
    re = 1'b0; ra = '0; we = 1'b0; wi = '0; wd = '0;
    cmd_o = '0; amount_o = size_q;
    cnt_ext = CXW'(cnt_i[pool_q]);

    if (mv_q && m_axis_tready_i) begin
      mv_d = 1'b0;
    end

    case (state_q)
      ffa_pkg::SEQ_IDLE: begin
        if (accept) begin
          kind_d = s_axis_tuser_i[0];
          pool_d = s_axis_tuser_i[1];
          size_d = s_axis_tdata_i[31:0];
          alg_d  = s_axis_tdata_i[36:32];
          boff_d = s_axis_tdata_i[68:37];
          n_d    = cnt_i[s_axis_tuser_i[1]];
          ridx_d = '0;
          prev_vld_d = 1'b0;
          cur_vld_d  = 1'b0;
          dir_d   = ffa_pkg::SH_NONE;
          wa_en_d = 1'b0;
          wb_en_d = 1'b0;
          status_d = ffa_pkg::ST_OK;
          aoff_d  = '0;
        end
      end
      ffa_pkg::SEQ_SCAN: begin
        if (!scan_end) begin
          re = 1'b1;
          ra = ridx_q;
          ridx_d = ridx_q + CNT_W'(1);
        end
        if (kind_q == ffa_pkg::KIND_FREE) begin
          if (rv_q && !ge) begin
            prev_off_d = e_off;
            prev_sz_d  = e_sz;
            prev_vld_d = 1'b1;
          end
          if (scan_end) begin
            j_d       = hit ? iidx : n_q;
            cur_vld_d = hit;
            cur_off_d = e_off;
            cur_sz_d  = e_sz;
          end
        end else if (scan_end) begin
          if (!hit) begin
            status_d = ffa_pkg::ST_NOFIT;
          end else if (pad != '0 && rem != '0 && n_q >= CNT_W'(MAX_FREE_BLOCKS)) begin
            status_d = ffa_pkg::ST_FULL;
          end else begin
            status_d  = ffa_pkg::ST_OK;
            aoff_d    = al[31:0];
            cmd_o.add = 1'b1;
            lo_d      = iidx;
            if (pad != '0 && rem != '0) begin
              dir_d    = ffa_pkg::SH_UP;
              sh_d     = n_q;
              cmd_o.inc = 1'b1;
              wa_en_d  = 1'b1;
              wa_idx_d = iidx;
              wa_off_d = e_off;
              wa_sz_d  = pad[ADDR_BITS-1:0];
              wb_en_d  = 1'b1;
              wb_idx_d = ridx_q;
              wb_off_d = OW'(al + CW'(size_q));
              wb_sz_d  = rem[ADDR_BITS-1:0];
            end else if (pad != '0) begin
              wa_en_d  = 1'b1;
              wa_idx_d = iidx;
              wa_off_d = e_off;
              wa_sz_d  = pad[ADDR_BITS-1:0];
            end else if (rem == '0) begin
              dir_d     = ffa_pkg::SH_DOWN;
              sh_d      = ridx_q;
              cmd_o.dec = 1'b1;
            end else begin
              wa_en_d  = 1'b1;
              wa_idx_d = iidx;
              wa_off_d = OW'(al + CW'(size_q));
              wa_sz_d  = rem[ADDR_BITS-1:0];
            end
          end
        end
      end
      ffa_pkg::SEQ_FPLAN: begin
        amount_o = 32'(sizec);
        if (!mn && !mp && n_q >= CNT_W'(MAX_FREE_BLOCKS)) begin
          status_d = ffa_pkg::ST_FULL;
        end else begin
          cmd_o.sub = 1'b1;
          lo_d      = j_q;
          wa_en_d   = 1'b1;
          if (mn && mp) begin
            dir_d     = ffa_pkg::SH_DOWN;
            sh_d      = j_q + CNT_W'(1);
            cmd_o.dec = 1'b1;
            wa_idx_d  = j_q - CNT_W'(1);
            wa_off_d  = prev_off_q;
            wa_sz_d   = sat_both;
          end else if (mn) begin
            wa_idx_d = j_q;
            wa_off_d = OW'(boffc);
            wa_sz_d  = sat_next;
          end else if (mp) begin
            wa_idx_d = j_q - CNT_W'(1);
            wa_off_d = prev_off_q;
            wa_sz_d  = sat_prev;
          end else begin
            dir_d     = ffa_pkg::SH_UP;
            sh_d      = n_q;
            cmd_o.inc = 1'b1;
            wa_idx_d  = j_q;
            wa_off_d  = OW'(boffc);
            wa_sz_d   = sizec;
          end
        end
      end
      ffa_pkg::SEQ_SHIFT: begin
        if (sh_issue) begin
          re = 1'b1;
          if (dir_q == ffa_pkg::SH_UP) begin
            ra    = sh_q - CNT_W'(1);
            sh_d  = sh_q - CNT_W'(1);
            shw_d = sh_q;
          end else begin
            ra    = sh_q;
            sh_d  = sh_q + CNT_W'(1);
            shw_d = sh_q - CNT_W'(1);
          end
        end
        if (rv_q) begin
          we = 1'b1;
          wi = shw_q;
          wd = {e_sz, e_off};
        end
      end
      ffa_pkg::SEQ_WRA: begin
        we = wa_en_q;
        wi = wa_idx_q;
        wd = {wa_sz_q, wa_off_q};
      end
      ffa_pkg::SEQ_WRB: begin
        we = wb_en_q;
        wi = wb_idx_q;
        wd = {wb_sz_q, wb_off_q};
      end
      ffa_pkg::SEQ_DONE: begin
        if (!mv_q || m_axis_tready_i) begin
          mv_d = 1'b1;
          md_d = {{MPAD{1'b0}}, cnt_ext[6:0], bytes_i[pool_q], aoff_q, status_q};
        end
      end
      default: begin
      end
    endcase

    cmd_o.clr_fresh = we && (wi == '0);
  end

  assign rfresh_d = re && (ra == '0) && fresh_i[pool_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffa_pkg::SEQ_IDLE;
      rv_q    <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= re;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rfresh_q <= rfresh_d;
    kind_q <= kind_d; pool_q <= pool_d; size_q <= size_d; boff_q <= boff_d; alg_q <= alg_d;
    n_q <= n_d; ridx_q <= ridx_d; j_q <= j_d; lo_q <= lo_d; sh_q <= sh_d; shw_q <= shw_d;
    dir_q <= dir_d;
    prev_off_q <= prev_off_d; prev_sz_q <= prev_sz_d; prev_vld_q <= prev_vld_d;
    cur_off_q <= cur_off_d; cur_sz_q <= cur_sz_d; cur_vld_q <= cur_vld_d;
    wa_en_q <= wa_en_d; wa_idx_q <= wa_idx_d; wa_off_q <= wa_off_d; wa_sz_q <= wa_sz_d;
    wb_en_q <= wb_en_d; wb_idx_q <= wb_idx_d; wb_off_q <= wb_off_d; wb_sz_q <= wb_sz_d;
    status_q <= status_d; aoff_q <= aoff_d;
    md_q <= md_d;
  end

  assign pool_o          = pool_q;
  assign ram_re_o        = re;
  assign ram_raddr_o     = {pool_q, ra[IW-1:0]};
  assign ram_we_o        = we;
  assign ram_waddr_o     = {pool_q, wi[IW-1:0]};
  assign ram_wdata_o     = wd;
  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = md_q;

endmodule

// File: rtl/ffa_checker.sv
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [ffa_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[1:0] == ffa_pkg::ST_OK
                         || m_axis_tdata_o[1:0] == ffa_pkg::ST_NOFIT
                         || m_axis_tdata_o[1:0] == ffa_pkg::ST_FULL))
    else $error("undefined status code");

  a_fail_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] != ffa_pkg::ST_OK |-> m_axis_tdata_o[33:2] == '0)
    else $error("failed request reports an offset");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while another is in flight");

endmodule

bind first_fit_aligned_free_list_allocator ffa_checker u_ffa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
